@@ src/remote_id_channel_table_defines.svh @@
// Assertion helpers used by the datapath RTL of the remote ID channel table.
`ifndef REMOTE_ID_CHANNEL_TABLE_DEFINES_SVH
`define REMOTE_ID_CHANNEL_TABLE_DEFINES_SVH

// A property checked at every clock edge outside reset.
`define RID_ASSERT(label, prop, msg) \
  label: assert property (@(posedge clk) disable iff (rst) prop) else $error(msg);

// A condition in one cycle that must be followed by a result in the next.
`define RID_ASSERT_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) else $error(msg);

`endif

@@ src/rid_pkg.sv @@
package rid_pkg;

  localparam int OP_W    = 3;
  localparam int ID_W    = 24;
  localparam int MASK_W  = 16;
  localparam int SLOT_W  = 5;
  localparam int TOTAL_W = 5;

  typedef enum logic [OP_W-1:0] {
    OP_LOOKUP = 3'd0,
    OP_SAVE   = 3'd1,
    OP_ADD    = 3'd2,
    OP_DELETE = 3'd3,
    OP_CLEAR  = 3'd4
  } op_t;

  typedef struct packed {
    logic [ID_W-1:0]   id;
    logic [MASK_W-1:0] mask;
  } entry_t;

  typedef enum logic [3:0] {
    S_IDLE,
    S_DISPATCH,
    S_SCAN_RD,
    S_SCAN_CMP,
    S_RMW_RD,
    S_RMW_WR,
    S_SHIFT,
    S_SHIFT_WR,
    S_FINISH
  } state_t;

  typedef enum logic {
    RD_AT_IDX,
    RD_AT_NEXT
  } rd_sel_t;

  typedef enum logic [1:0] {
    WR_SAVE,
    WR_MODIFY,
    WR_SHIFT,
    WR_ZERO
  } wr_sel_t;

  typedef struct packed {
    logic    load_item;
    logic    idx_zero;
    logic    idx_slot;
    logic    idx_inc;
    logic    rd_en;
    rd_sel_t rd_sel;
    logic    wr_en;
    wr_sel_t wr_sel;
    logic    save_update;
    logic    remove_update;
    logic    clear_all;
    logic    set_found;
    logic    set_overlap;
    logic    set_ok;
    logic    out_load;
  } ctrl_cmd_t;

  typedef struct packed {
    logic [OP_W-1:0] operation;
    logic            count_zero;
    logic            slot_ok;
    logic            id_match;
    logic            overlap_hit;
    logic            scan_last;
    logic            mod_mask_zero;
    logic            shift_more;
    logic            out_free;
  } ctrl_sts_t;

endpackage

@@ src/rid_item_if.sv @@
interface rid_item_if import rid_pkg::*; ();
  logic              valid;
  logic              ready;
  logic [OP_W-1:0]   operation;
  logic [ID_W-1:0]   remote_id;
  logic [MASK_W-1:0] channel_mask;
  logic [SLOT_W-1:0] slot;

  modport source (output valid, operation, remote_id, channel_mask, slot, input ready);
  modport sink (input valid, operation, remote_id, channel_mask, slot, output ready);
endinterface

@@ src/rid_result_if.sv @@
interface rid_result_if import rid_pkg::*; ();
  logic               valid;
  logic               ready;
  logic [SLOT_W-1:0]  found_slot;
  logic               channel_overlap;
  logic               done_ok;
  logic [TOTAL_W-1:0] entry_total;

  modport source (output valid, found_slot, channel_overlap, done_ok, entry_total,
                  input ready);
  modport sink (input valid, found_slot, channel_overlap, done_ok, entry_total,
                output ready);
endinterface

@@ src/rid_datapath.sv @@
`include "remote_id_channel_table_defines.svh"

module rid_datapath import rid_pkg::*; #(
  parameter int TABLE_ENTRIES = 16
) (
  input  logic              clk,
  input  logic              rst,
  input  logic [OP_W-1:0]   operation,
  input  logic [ID_W-1:0]   remote_id,
  input  logic [MASK_W-1:0] channel_mask,
  input  logic [SLOT_W-1:0] slot,
  input  ctrl_cmd_t         cmd,
  output ctrl_sts_t         sts,
  rid_result_if.source      result
);

  localparam int IDX_W = (TABLE_ENTRIES > 1) ? $clog2(TABLE_ENTRIES) : 1;
  localparam int CNT_W = $clog2(TABLE_ENTRIES + 1);

  entry_t             mem [TABLE_ENTRIES];
  entry_t             rd_data;
  logic [OP_W-1:0]    op_q;
  logic [ID_W-1:0]    id_q;
  logic [MASK_W-1:0]  mask_q;
  logic [SLOT_W-1:0]  slot_q;
  logic [IDX_W-1:0]   idx;
  logic [CNT_W-1:0]   count;
  logic [IDX_W-1:0]   ptr;
  logic [SLOT_W-1:0]  found;
  logic               overlap;
  logic               ok;
  logic               out_valid;
  logic [SLOT_W-1:0]  out_found;
  logic               out_overlap;
  logic               out_ok;
  logic [TOTAL_W-1:0] out_total;

  logic [CNT_W-1:0]   idx_plus1;
  logic [IDX_W-1:0]   rd_addr;
  logic [IDX_W-1:0]   wr_addr;
  entry_t             wr_data;
  entry_t             modified;

  assign idx_plus1 = CNT_W'(idx) + CNT_W'(1);

  always_comb begin
    modified = rd_data;
    if (op_q == OP_ADD) begin
      modified.mask = rd_data.mask | mask_q;
    end else begin
      modified.mask = rd_data.mask & ~mask_q;
    end
  end

  assign rd_addr = (cmd.rd_sel == RD_AT_NEXT) ? IDX_W'(idx_plus1) : idx;
  assign wr_addr = (cmd.wr_sel == WR_SAVE) ? ptr : idx;

  always_comb begin
    unique case (cmd.wr_sel)
      WR_SAVE:   wr_data = '{id: id_q, mask: mask_q};
      WR_MODIFY: wr_data = modified;
      WR_SHIFT:  wr_data = rd_data;
      WR_ZERO:   wr_data = '0;
      default:   wr_data = '0;
    endcase
  end

  // Entries at or above the used count are never read before being written,
  // so clearing the table only has to reset the count and the save pointer.
  always_ff @(posedge clk) begin
    if (cmd.wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    if (cmd.rd_en) begin
      rd_data <= mem[rd_addr];
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.load_item) begin
      op_q   <= operation;
      id_q   <= remote_id;
      mask_q <= channel_mask;
      slot_q <= slot;
    end
    if (cmd.idx_zero) begin
      idx <= '0;
    end else if (cmd.idx_slot) begin
      idx <= IDX_W'(slot_q - SLOT_W'(1));
    end else if (cmd.idx_inc) begin
      idx <= IDX_W'(idx_plus1);
    end
    if (cmd.load_item) begin
      found   <= '0;
      overlap <= 1'b0;
      ok      <= 1'b0;
    end else begin
      if (cmd.set_found) begin
        found <= SLOT_W'(idx_plus1);
      end
      if (cmd.set_overlap) begin
        overlap <= 1'b1;
      end
      if (cmd.set_ok) begin
        ok <= 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst || cmd.clear_all) begin
      count <= '0;
      ptr   <= '0;
    end else if (cmd.save_update) begin
      if (count < CNT_W'(TABLE_ENTRIES)) begin
        count <= count + CNT_W'(1);
      end
      if (ptr != IDX_W'(TABLE_ENTRIES - 1)) begin
        ptr <= ptr + IDX_W'(1);
      end
    end else if (cmd.remove_update) begin
      if (count != '0) begin
        count <= count - CNT_W'(1);
      end
      if (ptr != '0) begin
        ptr <= ptr - IDX_W'(1);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (cmd.out_load) begin
      out_valid <= 1'b1;
    end else if (result.ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.out_load) begin
      out_found   <= found;
      out_overlap <= overlap;
      out_ok      <= ok;
      out_total   <= TOTAL_W'(count);
    end
  end

  assign result.valid           = out_valid;
  assign result.found_slot      = out_found;
  assign result.channel_overlap = out_overlap;
  assign result.done_ok         = out_ok;
  assign result.entry_total     = out_total;

  always_comb begin
    sts.operation     = op_q;
    sts.count_zero    = (count == '0);
    sts.slot_ok       = (slot_q != '0) && (slot_q <= SLOT_W'(count));
    sts.id_match      = (rd_data.id == id_q);
    sts.overlap_hit   = ((rd_data.mask & mask_q) != '0);
    sts.scan_last     = (idx_plus1 >= count);
    sts.mod_mask_zero = (modified.mask == '0);
    sts.shift_more    = (idx_plus1 < count);
    sts.out_free      = !out_valid || result.ready;
  end

  `RID_ASSERT(count_in_range, count <= CNT_W'(TABLE_ENTRIES), "used count above table size")
  `RID_ASSERT(ptr_within_count, CNT_W'(ptr) <= count, "save pointer beyond used count")
  `RID_ASSERT(found_within_total, out_valid |-> out_found <= out_total, "found slot above total")
  `RID_ASSERT(overlap_needs_slot, out_valid && out_overlap |-> out_found != '0, "overlap with no slot")
  `RID_ASSERT_NEXT(clear_empties, cmd.clear_all, count == '0 && ptr == '0, "clear left entries")

endmodule

@@ src/rid_controller.sv @@
module rid_controller import rid_pkg::*; (
  input  logic      clk,
  input  logic      rst,
  input  logic      item_valid,
  output logic      item_ready,
  input  ctrl_sts_t sts,
  output ctrl_cmd_t cmd
);

  state_t state;
  state_t state_next;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
    end else begin
      state <= state_next;
    end
  end

  always_comb begin
    state_next = state;
    cmd        = '0;
    item_ready = 1'b0;
    unique case (state)
      S_IDLE: begin
        item_ready = 1'b1;
        if (item_valid) begin
          cmd.load_item = 1'b1;
          state_next    = S_DISPATCH;
        end
      end
      S_DISPATCH: begin
        unique case (sts.operation)
          OP_LOOKUP: begin
            cmd.idx_zero = 1'b1;
            state_next   = sts.count_zero ? S_FINISH : S_SCAN_RD;
          end
          OP_SAVE: begin
            cmd.wr_en       = 1'b1;
            cmd.wr_sel      = WR_SAVE;
            cmd.save_update = 1'b1;
            cmd.set_ok      = 1'b1;
            state_next      = S_FINISH;
          end
          OP_ADD, OP_DELETE: begin
            if (sts.slot_ok) begin
              cmd.idx_slot = 1'b1;
              state_next   = S_RMW_RD;
            end else begin
              state_next = S_FINISH;
            end
          end
          OP_CLEAR: begin
            cmd.clear_all = 1'b1;
            state_next    = S_FINISH;
          end
          default: begin
            state_next = S_FINISH;
          end
        endcase
      end
      S_SCAN_RD: begin
        cmd.rd_en  = 1'b1;
        cmd.rd_sel = RD_AT_IDX;
        state_next = S_SCAN_CMP;
      end
      S_SCAN_CMP: begin
        // The scan ends early only on a match whose channels overlap.
        if (sts.id_match) begin
          cmd.set_found = 1'b1;
        end
        if (sts.id_match && sts.overlap_hit) begin
          cmd.set_overlap = 1'b1;
          state_next      = S_FINISH;
        end else if (sts.scan_last) begin
          state_next = S_FINISH;
        end else begin
          cmd.idx_inc = 1'b1;
          state_next  = S_SCAN_RD;
        end
      end
      S_RMW_RD: begin
        cmd.rd_en  = 1'b1;
        cmd.rd_sel = RD_AT_IDX;
        state_next = S_RMW_WR;
      end
      S_RMW_WR: begin
        cmd.wr_en  = 1'b1;
        cmd.wr_sel = WR_MODIFY;
        cmd.set_ok = 1'b1;
        if ((sts.operation == OP_DELETE) && sts.mod_mask_zero) begin
          state_next = S_SHIFT;
        end else begin
          state_next = S_FINISH;
        end
      end
      S_SHIFT: begin
        // Move later entries down one place, then zero the vacated top slot.
        if (sts.shift_more) begin
          cmd.rd_en  = 1'b1;
          cmd.rd_sel = RD_AT_NEXT;
          state_next = S_SHIFT_WR;
        end else begin
          cmd.wr_en         = 1'b1;
          cmd.wr_sel        = WR_ZERO;
          cmd.remove_update = 1'b1;
          state_next        = S_FINISH;
        end
      end
      S_SHIFT_WR: begin
        cmd.wr_en   = 1'b1;
        cmd.wr_sel  = WR_SHIFT;
        cmd.idx_inc = 1'b1;
        state_next  = S_SHIFT;
      end
      S_FINISH: begin
        if (sts.out_free) begin
          cmd.out_load = 1'b1;
          state_next   = S_IDLE;
        end
      end
      default: begin
        state_next = S_IDLE;
      end
    endcase
  end

endmodule

@@ src/remote_id_channel_table.sv @@
// Remote ID channel table: up to TABLE_ENTRIES entries, each a 24-bit remote
// ID with a 16-bit channel mask. Commands arrive on the item channel
// (operation, remote_id, channel_mask, slot); each transaction produces one
// transaction on the result channel (found_slot, channel_overlap, done_ok,
// entry_total). Both channels use a valid/ready handshake.
// One command is worked on at a time; item.ready is high only while the
// sequencer is idle. Save and clear finish in the dispatch step, add and an
// ordinary delete read and then write back the addressed entry, a lookup
// reads and compares entries in turn, and a delete that removes an entry
// then moves each later entry down with a read and a write and zeroes the
// vacated top slot. Each command ends by loading the result register.
// The result sits in an output register, so the next command is accepted
// while a result still waits; a stalled receiver holds the sequencer only
// when the following result is ready to be loaded.
// Synchronous reset empties the table (used count and save pointer to zero),
// drops any pending result and returns the sequencer to idle at once; the
// table memory itself needs no clearing pass.
module remote_id_channel_table import rid_pkg::*; #(
  parameter int TABLE_ENTRIES = 16
) (
  input logic         clk,
  input logic         rst,
  rid_item_if.sink    item,
  rid_result_if.source result
);

  ctrl_cmd_t cmd;
  ctrl_sts_t sts;
  logic      item_ready;

  assign item.ready = item_ready;

  rid_controller u_controller (
    .clk        (clk),
    .rst        (rst),
    .item_valid (item.valid),
    .item_ready (item_ready),
    .sts        (sts),
    .cmd        (cmd)
  );

  rid_datapath #(
    .TABLE_ENTRIES (TABLE_ENTRIES)
  ) u_datapath (
    .clk          (clk),
    .rst          (rst),
    .operation    (item.operation),
    .remote_id    (item.remote_id),
    .channel_mask (item.channel_mask),
    .slot         (item.slot),
    .cmd          (cmd),
    .sts          (sts),
    .result       (result)
  );

endmodule
